### design/pcp_pkg.sv
// Shared widths, constants and latencies of the pair contact probability block.
package pcp_pkg;

	// Field widths
	localparam int COORD_W = 23;
	localparam int RAD_W   = 16;
	localparam int DIST_W  = 24;
	localparam int PROB_W  = 17;

	// Datapath widths
	localparam int DIFF_W = COORD_W;          // |a - b| of two coordinates
	localparam int SQ_W   = 2 * DIFF_W;       // one squared component
	localparam int SUM_W  = SQ_W + 2;         // sum of three squares
	localparam int ROOT_W = SUM_W / 2;        // square root bits, one per stage
	localparam int D_W    = RAD_W + 1;        // distance inside the lens range
	localparam int NUM_W  = 86;               // t1^2 * f * 2^16
	localparam int DEN_W  = 69;               // 16 * d * r^3
	localparam int QB     = PROB_W;           // quotient bits from the divider

	// Constants
	localparam logic [RAD_W-1:0]  RC_RESET = 16'd3072;
	localparam logic [PROB_W-1:0] Q16_ONE  = 17'h10000;

	// Latencies in cycles
	localparam int FRONT_LAT = 3;
	localparam int DIR_LAT   = 7 + QB + 1;
	localparam int PIPE_LAT  = FRONT_LAT + ROOT_W + DIR_LAT + 1;

endpackage

### design/pcp_if.sv
// Channel interfaces for residue pair beats and result beats.
interface pcp_pair_if;
	logic                               valid;
	logic                               ready;
	logic signed [pcp_pkg::COORD_W-1:0] first_x;
	logic signed [pcp_pkg::COORD_W-1:0] first_y;
	logic signed [pcp_pkg::COORD_W-1:0] first_z;
	logic signed [pcp_pkg::COORD_W-1:0] second_x;
	logic signed [pcp_pkg::COORD_W-1:0] second_y;
	logic signed [pcp_pkg::COORD_W-1:0] second_z;
	logic        [pcp_pkg::RAD_W-1:0]   error_ab;
	logic        [pcp_pkg::RAD_W-1:0]   error_ba;
	logic                               diagonal;

	modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		error_ab, error_ba, diagonal, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		error_ab, error_ba, diagonal, output ready);
endinterface

interface pcp_result_if;
	logic                        valid;
	logic                        ready;
	logic [pcp_pkg::DIST_W-1:0]  distance;
	logic [pcp_pkg::PROB_W-1:0]  prob_ab;
	logic [pcp_pkg::PROB_W-1:0]  prob_ba;
	logic [pcp_pkg::PROB_W-1:0]  prob_mean;
	logic                        in_contact;

	modport source (output valid, distance, prob_ab, prob_ba, prob_mean, in_contact,
		input ready);
	modport sink (input valid, distance, prob_ab, prob_ba, prob_mean, in_contact,
		output ready);
endinterface

### design/pair_contact_probability.sv
// Top level of the pair contact probability pipeline.
// Takes one residue pair beat per clock while the output is not held and returns one result
// beat per pair, in order: the squared distance is formed, the square root runs one result
// bit per stage, the two direction units run (products, then a 17-stage restoring divider),
// and a final stage forms the mean and contact flag.
// The whole pipeline advances together; while a result beat is held at the output,
// every stage holds and no new pair is taken. The contact radius register takes effect
// on the next accepted pair and must be written only while no pair is in flight.
module pair_contact_probability (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [pcp_pkg::RAD_W-1:0]  cfg_wr_data,
	pcp_pair_if.sink                   pair,
	pcp_result_if.source               result
);
	import pcp_pkg::*;

	typedef struct packed {
		logic             diag;
		logic [RAD_W-1:0] rab;
		logic [RAD_W-1:0] rba;
	} side_t;

	function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b);
		logic [COORD_W:0] t;
		t = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		if (t[COORD_W]) begin
			t = ~t + 1'b1;
		end
		return t[DIFF_W-1:0];
	endfunction

	// Contact radius register
	logic [RAD_W-1:0] rc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= RC_RESET;
		end else if (cfg_wr_en) begin
			rc_q <= cfg_wr_data;
		end
	end

	// Pipeline enable and valid bits
	logic                en;
	logic [PIPE_LAT-1:0] vld_s;

	assign en         = ~vld_s[PIPE_LAT-1] | result.ready;
	assign pair.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], pair.valid};
		end
	end

	// Stage 1: coordinate differences
	logic [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	side_t             side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1        <= abs_diff(pair.first_x, pair.second_x);
			dy_s1        <= abs_diff(pair.first_y, pair.second_y);
			dz_s1        <= abs_diff(pair.first_z, pair.second_z);
			side_s1.diag <= pair.diagonal;
			side_s1.rab  <= pair.error_ab;
			side_s1.rba  <= pair.error_ba;
		end
	end

	// Stage 2: squares
	logic [SQ_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	side_t           side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
			sqy_s2  <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
			sqz_s2  <= SQ_W'(dz_s1) * SQ_W'(dz_s1);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: sum of squares
	logic [SUM_W-1:0] sum_s3;
	side_t            side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
			side_s3 <= side_s2;
		end
	end

	// Square root: one result bit per stage
	logic [SUM_W-1:0] rt_n_s    [ROOT_W];
	logic [SUM_W-1:0] rt_r_s    [ROOT_W];
	side_t            rt_side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - k));
		logic [SUM_W-1:0] n_in, r_in, trial;
		side_t            side_in;

		if (k == 0) begin : g_first
			assign n_in    = sum_s3;
			assign r_in    = '0;
			assign side_in = side_s3;
		end else begin : g_next
			assign n_in    = rt_n_s[k-1];
			assign r_in    = rt_r_s[k-1];
			assign side_in = rt_side_s[k-1];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				rt_side_s[k] <= side_in;
				if (n_in >= trial) begin
					rt_n_s[k] <= n_in - trial;
					rt_r_s[k] <= (r_in >> 1) + BIT;
				end else begin
					rt_n_s[k] <= n_in;
					rt_r_s[k] <= r_in >> 1;
				end
			end
		end
	end

	// The root of a sum of three squared 23-bit differences always fits the distance field
	logic [DIST_W-1:0] root_dist;
	side_t             side_rt;

	assign root_dist = rt_r_s[ROOT_W-1][DIST_W-1:0];
	assign side_rt   = rt_side_s[ROOT_W-1];

	// Direction units
	logic [PROB_W-1:0] prob_ab, prob_ba;

	pcp_dir u_dir_ab (
		.clk  (clk),
		.en   (en),
		.d    (root_dist),
		.r    (side_rt.rab),
		.rc   (rc_q),
		.prob (prob_ab)
	);

	pcp_dir u_dir_ba (
		.clk  (clk),
		.en   (en),
		.d    (root_dist),
		.r    (side_rt.rba),
		.rc   (rc_q),
		.prob (prob_ba)
	);

	// Delay distance and diagonal flag alongside the direction units
	logic [DIST_W-1:0] dl_dist_s [DIR_LAT];
	logic              dl_diag_s [DIR_LAT];

	for (genvar k = 0; k < DIR_LAT; k++) begin : g_delay
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					dl_dist_s[k] <= root_dist;
					dl_diag_s[k] <= side_rt.diag;
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					dl_dist_s[k] <= dl_dist_s[k-1];
					dl_diag_s[k] <= dl_diag_s[k-1];
				end
			end
		end
	end

	// Output stage: mean, contact flag, diagonal override
	logic [DIST_W-1:0] dist_out_s;
	logic [PROB_W-1:0] pab_out_s, pba_out_s, mean_out_s;
	logic              contact_out_s;
	logic [PROB_W:0]   psum;
	logic [DIST_W-1:0] dist_d;

	assign psum   = {1'b0, prob_ab} + {1'b0, prob_ba};
	assign dist_d = dl_dist_s[DIR_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (dl_diag_s[DIR_LAT-1]) begin
				dist_out_s    <= '0;
				pab_out_s     <= Q16_ONE;
				pba_out_s     <= Q16_ONE;
				mean_out_s    <= Q16_ONE;
				contact_out_s <= rc_q != '0;
			end else begin
				dist_out_s    <= dist_d;
				pab_out_s     <= prob_ab;
				pba_out_s     <= prob_ba;
				mean_out_s    <= psum[PROB_W:1];
				contact_out_s <= dist_d < DIST_W'(rc_q);
			end
		end
	end

	assign result.valid      = vld_s[PIPE_LAT-1];
	assign result.distance   = dist_out_s;
	assign result.prob_ab    = pab_out_s;
	assign result.prob_ba    = pba_out_s;
	assign result.prob_mean  = mean_out_s;
	assign result.in_contact = contact_out_s;

	// Checks
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.prob_mean <= Q16_ONE)
		else $error("mean probability above one");

	a_contact_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.in_contact && result.distance != '0
		|-> result.distance < DIST_W'(rc_q))
		else $error("contact flagged at or beyond the contact radius");

	a_both_one: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.prob_ab == Q16_ONE && result.prob_ba == Q16_ONE
		|-> result.prob_mean == Q16_ONE)
		else $error("mean of two certain contacts is not one");

endmodule

### design/pcp_dir.sv
// One direction: fraction of the error sphere inside the contact sphere, Q1.16.
module pcp_dir (
	input  logic                        clk,
	input  logic                        en,
	input  logic [pcp_pkg::DIST_W-1:0]  d,
	input  logic [pcp_pkg::RAD_W-1:0]   r,
	input  logic [pcp_pkg::RAD_W-1:0]   rc,
	output logic [pcp_pkg::PROB_W-1:0]  prob
);
	import pcp_pkg::*;

	typedef struct packed {
		logic zero;
		logic one;
		logic cont;
	} case_t;

	typedef struct packed {
		logic zero;
		logic one;
		logic sat;
	} dflag_t;

	// Stage 1: classify against the contact sphere
	logic [RAD_W:0]   rsum;
	logic [RAD_W-1:0] diff;
	logic             far, nested, rc_ge;
	case_t            cs_s1;
	logic [D_W-1:0]   d_s1, t1_s1, sum_s1;
	logic [RAD_W-1:0] diff_s1, r_s1, rc_s1;

	always_comb begin
		rsum   = {1'b0, r} + {1'b0, rc};
		rc_ge  = rc >= r;
		diff   = rc_ge ? rc - r : r - rc;
		far    = d >= DIST_W'(rsum);
		nested = d <= DIST_W'(diff);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s1.zero <= (r == '0) | far;
			cs_s1.one  <= ~((r == '0) | far) & nested & rc_ge;
			cs_s1.cont <= ~((r == '0) | far) & nested & ~rc_ge;
			d_s1       <= d[D_W-1:0];
			t1_s1      <= rsum - d[D_W-1:0];
			sum_s1     <= rsum;
			diff_s1    <= diff;
			r_s1       <= r;
			rc_s1      <= rc;
		end
	end

	// Stage 2: first round of products
	case_t               cs_s2;
	logic [D_W-1:0]      d_s2;
	logic [RAD_W-1:0]    r_s2, rc_s2;
	logic [2*D_W-1:0]    dd_s2, dsum_s2, t1sq_s2;
	logic [2*RAD_W-1:0]  diffsq_s2, r2_s2, rc2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s2     <= cs_s1;
			d_s2      <= d_s1;
			r_s2      <= r_s1;
			rc_s2     <= rc_s1;
			dd_s2     <= (2*D_W)'(d_s1) * (2*D_W)'(d_s1);
			dsum_s2   <= (2*D_W)'(d_s1) * (2*D_W)'(sum_s1);
			t1sq_s2   <= (2*D_W)'(t1_s1) * (2*D_W)'(t1_s1);
			diffsq_s2 <= (2*RAD_W)'(diff_s1) * (2*RAD_W)'(diff_s1);
			r2_s2     <= (2*RAD_W)'(r_s1) * (2*RAD_W)'(r_s1);
			rc2_s2    <= (2*RAD_W)'(rc_s1) * (2*RAD_W)'(rc_s1);
		end
	end

	// Stage 3: lens terms and cubes
	case_t               cs_s3;
	logic [D_W-1:0]      d_s3;
	logic [2*D_W-1:0]    t1sq_s3;
	logic [2*D_W+1:0]    pos_s3;
	logic [2*RAD_W+1:0]  neg_s3;
	logic [3*RAD_W-1:0]  r3_s3, rc3_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s3   <= cs_s2;
			d_s3    <= d_s2;
			t1sq_s3 <= t1sq_s2;
			pos_s3  <= (2*D_W+2)'(dd_s2) + ((2*D_W+2)'(dsum_s2) << 1);
			neg_s3  <= (2*RAD_W+2)'(diffsq_s2) + ((2*RAD_W+2)'(diffsq_s2) << 1);
			r3_s3   <= (3*RAD_W)'(r2_s2) * (3*RAD_W)'(r_s2);
			rc3_s3  <= (3*RAD_W)'(rc2_s2) * (3*RAD_W)'(rc_s2);
		end
	end

	// Stage 4: lens factor f and split d * r^3
	localparam int HALF3 = 3 * RAD_W / 2;
	localparam int FW    = 2 * D_W + 2;
	localparam int FH    = FW / 2;

	case_t                  cs_s4;
	logic                   fpos_s4;
	logic [FW-1:0]          f_s4;
	logic [2*D_W-1:0]       t1sq_s4;
	logic [3*RAD_W-1:0]     r3_s4, rc3_s4;
	logic [D_W+HALF3-1:0]   drlo_s4, drhi_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s4   <= cs_s3;
			fpos_s4 <= pos_s3 > FW'(neg_s3);
			f_s4    <= pos_s3 - FW'(neg_s3);
			t1sq_s4 <= t1sq_s3;
			r3_s4   <= r3_s3;
			rc3_s4  <= rc3_s3;
			drlo_s4 <= (D_W+HALF3)'(d_s3) * (D_W+HALF3)'(r3_s3[HALF3-1:0]);
			drhi_s4 <= (D_W+HALF3)'(d_s3) * (D_W+HALF3)'(r3_s3[3*RAD_W-1:HALF3]);
		end
	end

	// Stage 5: split t1^2 * f, assemble the lens denominator
	localparam int PW = 2 * D_W + FH;

	case_t               cs_s5;
	logic                fpos_s5;
	logic [3*RAD_W-1:0]  r3_s5, rc3_s5;
	logic [PW-1:0]       plo_s5, phi_s5;
	logic [DEN_W-1:0]    den_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s5   <= cs_s4;
			fpos_s5 <= fpos_s4;
			r3_s5   <= r3_s4;
			rc3_s5  <= rc3_s4;
			plo_s5  <= PW'(t1sq_s4) * PW'(f_s4[FH-1:0]);
			phi_s5  <= PW'(t1sq_s4) * PW'(f_s4[FW-1:FH]);
			den_s5  <= ((DEN_W'(drhi_s4) << HALF3) + DEN_W'(drlo_s4)) << 4;
		end
	end

	// Stage 6: pick numerator and denominator for the divider
	dflag_t            fl_s6;
	logic [NUM_W-1:0]  num_s6;
	logic [DEN_W-1:0]  den_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s6.zero <= cs_s5.zero | (~cs_s5.one & ~cs_s5.cont & ~fpos_s5);
			fl_s6.one  <= cs_s5.one;
			fl_s6.sat  <= 1'b0;
			if (cs_s5.cont) begin
				num_s6 <= NUM_W'(rc3_s5) << 16;
				den_s6 <= DEN_W'(r3_s5);
			end else begin
				num_s6 <= ((NUM_W'(phi_s5) << FH) + NUM_W'(plo_s5)) << 16;
				den_s6 <= den_s5;
			end
		end
	end

	// Stage 7: detect a quotient of at least two
	dflag_t            fl_s7;
	logic [NUM_W-1:0]  rem_s7;
	logic [DEN_W-1:0]  den_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s7.zero <= fl_s6.zero;
			fl_s7.one  <= fl_s6.one;
			fl_s7.sat  <= num_s6 >= (NUM_W'(den_s6) << QB);
			rem_s7     <= num_s6;
			den_s7     <= den_s6;
		end
	end

	// Divider: one quotient bit per stage, most significant first
	dflag_t            dv_fl_s [QB];
	logic [NUM_W-1:0]  dv_rem_s [QB];
	logic [DEN_W-1:0]  dv_den_s [QB];
	logic [QB-1:0]     dv_q_s   [QB];

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [NUM_W-1:0] rem_in, shifted;
		logic [DEN_W-1:0] den_in;
		logic [QB-1:0]    q_in;
		dflag_t           fl_in;

		if (j == 0) begin : g_first
			assign rem_in = rem_s7;
			assign den_in = den_s7;
			assign q_in   = '0;
			assign fl_in  = fl_s7;
		end else begin : g_next
			assign rem_in = dv_rem_s[j-1];
			assign den_in = dv_den_s[j-1];
			assign q_in   = dv_q_s[j-1];
			assign fl_in  = dv_fl_s[j-1];
		end

		assign shifted = NUM_W'(den_in) << (QB - 1 - j);

		always_ff @(posedge clk) begin
			if (en) begin
				dv_fl_s[j]  <= fl_in;
				dv_den_s[j] <= den_in;
				if (rem_in >= shifted) begin
					dv_rem_s[j] <= rem_in - shifted;
					dv_q_s[j]   <= q_in | (QB'(1) << (QB - 1 - j));
				end else begin
					dv_rem_s[j] <= rem_in;
					dv_q_s[j]   <= q_in;
				end
			end
		end
	end

	// Final stage: apply the special cases and clamp to one
	dflag_t        fl_last;
	logic [QB-1:0] q_last;

	assign fl_last = dv_fl_s[QB-1];
	assign q_last  = dv_q_s[QB-1];

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (fl_last.zero) begin
				prob <= '0;
			end else if (fl_last.one || fl_last.sat || q_last > Q16_ONE) begin
				prob <= Q16_ONE;
			end else begin
				prob <= q_last;
			end
		end
	end

endmodule

### dv/tb_pair_contact_probability.sv
// Self-checking testbench for the pair contact probability pipeline.
`timescale 1ns / 100ps

module tb_pair_contact_probability;
	import pcp_pkg::*;

	typedef struct {
		logic signed [COORD_W-1:0] fx, fy, fz, sx, sy, sz;
		logic [RAD_W-1:0]          err_ab, err_ba;
		logic                      diag;
	} pair_t;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic [PROB_W-1:0] prob_ab, prob_ba, prob_mean;
		logic              in_contact;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [RAD_W-1:0] cfg_wr_data = '0;

	pcp_pair_if   pair ();
	pcp_result_if result ();

	pair_contact_probability dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pair        (pair.sink),
		.result      (result.source)
	);

	pair_t    pending_pairs[$];
	contact_t expected_contacts[$];
	logic [RAD_W-1:0] radius_shadow = RC_RESET;
	bit  failed = 0;
	bit  pair_taken = 0;
	bit  result_taken = 0;
	bit  burst = 0;
	int  send_gap = 0;
	int  recv_stall = 0;

	always #5 clk = ~clk;

	// Floor square root of a 64-bit value, digit by digit
	function automatic logic [63:0] floor_root(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Fraction of the error sphere inside the contact sphere, Q1.16
	function automatic logic [PROB_W-1:0] sphere_fraction(logic [63:0] r, logic [63:0] rc,
			logic [63:0] d);
		logic [63:0]  gap, t1, pos, neg;
		logic [127:0] num, den, q;
		if (r == 0 || d >= rc + r) return '0;
		gap = (rc > r) ? rc - r : r - rc;
		if (d <= gap) begin
			if (rc >= r) return Q16_ONE;
			num = {64'd0, rc * rc * rc} << 16;
			den = {64'd0, r * r * r};
		end else begin
			t1 = rc + r - d;
			pos = d * d + 2 * d * (r + rc);
			neg = 3 * gap * gap;
			if (pos <= neg) return '0;
			num = ({64'd0, t1 * t1} * {64'd0, pos - neg}) << 16;
			den = {64'd0, 16 * d} * {64'd0, r * r * r};
		end
		q = num / den;
		return (q > 128'd65536) ? Q16_ONE : q[PROB_W-1:0];
	endfunction

	function automatic contact_t predict_contact(pair_t p, logic [RAD_W-1:0] rc);
		contact_t c;
		logic [63:0] dx, dy, dz, d;
		if (p.diag) begin
			c.distance = '0;
			c.prob_ab = Q16_ONE;
			c.prob_ba = Q16_ONE;
			c.prob_mean = Q16_ONE;
			c.in_contact = (rc != 0);
			return c;
		end
		dx = 64'(p.fx > p.sx ? 64'(p.fx) - 64'(p.sx) : 64'(p.sx) - 64'(p.fx));
		dy = 64'(p.fy > p.sy ? 64'(p.fy) - 64'(p.sy) : 64'(p.sy) - 64'(p.fy));
		dz = 64'(p.fz > p.sz ? 64'(p.fz) - 64'(p.sz) : 64'(p.sz) - 64'(p.fz));
		d = floor_root(dx * dx + dy * dy + dz * dz);
		if (d > 64'hFFFFFF) d = 64'hFFFFFF;
		c.distance = d[DIST_W-1:0];
		c.prob_ab = sphere_fraction(64'(p.err_ab), 64'(rc), d);
		c.prob_ba = sphere_fraction(64'(p.err_ba), 64'(rc), d);
		c.prob_mean = 17'((18'(c.prob_ab) + 18'(c.prob_ba)) >> 1);
		c.in_contact = (d < 64'(rc));
		return c;
	endfunction

	// Track input beats and predict their results
	always @(posedge clk) begin
		pair_taken <= pair.valid && pair.ready;
		if (pair.valid && pair.ready)
			expected_contacts.push_back(predict_contact('{pair.first_x, pair.first_y,
				pair.first_z, pair.second_x, pair.second_y, pair.second_z, pair.error_ab,
				pair.error_ba, pair.diagonal}, radius_shadow));
	end

	// Drive pair beats, holding each until taken, with random gaps
	always @(negedge clk) begin
		pair_t p;
		if (!arst_n) begin
			pair.valid <= 1'b0;
		end else if (pair.valid && !pair_taken) begin
		end else if (send_gap > 0) begin
			pair.valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_pairs.size() != 0) begin
			p = pending_pairs.pop_front();
			pair.first_x <= p.fx;
			pair.first_y <= p.fy;
			pair.first_z <= p.fz;
			pair.second_x <= p.sx;
			pair.second_y <= p.sy;
			pair.second_z <= p.sz;
			pair.error_ab <= p.err_ab;
			pair.error_ba <= p.err_ba;
			pair.diagonal <= p.diag;
			pair.valid <= 1'b1;
			if ($urandom_range(0, 40) == 0) burst = ~burst;
			send_gap <= burst ? 0 : $urandom_range(0, 12);
		end else begin
			pair.valid <= 1'b0;
		end
	end

	// Stall the result side at random after each beat
	always @(negedge clk) begin
		if (result_taken) recv_stall = burst ? 0 : $urandom_range(0, 12);
		if (recv_stall > 0) begin
			result.ready <= 1'b0;
			recv_stall = recv_stall - 1;
		end else begin
			result.ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin
		contact_t e;
		result_taken <= result.valid && result.ready;
		if (arst_n && result.valid && result.ready) begin
			if (expected_contacts.size() == 0) begin
				$error("result beat with no pair outstanding");
				failed = 1;
			end else begin
				e = expected_contacts.pop_front();
				if (result.distance !== e.distance) begin
					$error("distance: expected %0d, got %0d", e.distance, result.distance);
					failed = 1;
				end
				if (result.prob_ab !== e.prob_ab) begin
					$error("prob_ab: expected %0d, got %0d", e.prob_ab, result.prob_ab);
					failed = 1;
				end
				if (result.prob_ba !== e.prob_ba) begin
					$error("prob_ba: expected %0d, got %0d", e.prob_ba, result.prob_ba);
					failed = 1;
				end
				if (result.prob_mean !== e.prob_mean) begin
					$error("prob_mean: expected %0d, got %0d", e.prob_mean, result.prob_mean);
					failed = 1;
				end
				if (result.in_contact !== e.in_contact) begin
					$error("in_contact: expected %0d, got %0d", e.in_contact,
						result.in_contact);
					failed = 1;
				end
			end
		end
	end

	function automatic pair_t make_pair(int fx, int fy, int fz, int sx, int sy, int sz,
			int eab, int eba, int dg);
		pair_t p;
		p.fx = COORD_W'(fx); p.fy = COORD_W'(fy); p.fz = COORD_W'(fz);
		p.sx = COORD_W'(sx); p.sy = COORD_W'(sy); p.sz = COORD_W'(sz);
		p.err_ab = eab[RAD_W-1:0];
		p.err_ba = eba[RAD_W-1:0];
		p.diag = dg[0];
		return p;
	endfunction

	function automatic int rand_error();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 2048);
			1: return $urandom_range(0, 8192);
			2: return $urandom_range(0, 65535);
			default: return (radius_shadow + $urandom_range(0, 512)) & 16'hFFFF;
		endcase
	endfunction

	// Random pair: mostly close neighbours, some anywhere in the full width
	function automatic pair_t random_pair();
		pair_t p;
		int span;
		p.fx = COORD_W'($urandom); p.fy = COORD_W'($urandom); p.fz = COORD_W'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			p.sx = COORD_W'($urandom); p.sy = COORD_W'($urandom); p.sz = COORD_W'($urandom);
		end else begin
			case ($urandom_range(0, 2))
				0: span = 512;
				1: span = 8192;
				default: span = 40000;
			endcase
			p.sx = p.fx + COORD_W'($urandom_range(0, 2 * span) - span);
			p.sy = p.fy + COORD_W'($urandom_range(0, 2 * span) - span);
			p.sz = p.fz + COORD_W'($urandom_range(0, 2 * span) - span);
		end
		p.err_ab = RAD_W'(rand_error());
		p.err_ba = RAD_W'(rand_error());
		p.diag = ($urandom_range(0, 9) == 0);
		return p;
	endfunction

	// Wait until every pair has left the pipeline
	task automatic drain();
		while (pending_pairs.size() != 0 || pair.valid || expected_contacts.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	task automatic write_radius(logic [RAD_W-1:0] rc);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= rc;
		radius_shadow = rc;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		logic [RAD_W-1:0] radii[6];
		pair.valid = 1'b0;
		pair.first_x = '0; pair.first_y = '0; pair.first_z = '0;
		pair.second_x = '0; pair.second_y = '0; pair.second_z = '0;
		pair.error_ab = '0; pair.error_ba = '0; pair.diagonal = 1'b0;
		result.ready = 1'b0;
		radii = '{16'd3072, 16'd0, 16'd65535, 16'd1, 16'd700, 16'd20000};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed pairs at the reset radius
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1));
		pending_pairs.push_back(make_pair(5, 6, 7, 1000, 2000, 3000, 65535, 65535, 1));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 256, 65535, 0));
		pending_pairs.push_back(make_pair(-2560000, -2560000, -2560000,
			2560000, 2560000, 2560000, 65535, 1, 0));
		pending_pairs.push_back(make_pair(-4194304, -4194304, -4194304,
			4194303, 4194303, 4194303, 65535, 65535, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 3328, 0, 0, 256, 256, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 3327, 0, 0, 256, 256, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 2816, 0, 0, 256, 256, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 2817, 0, 0, 256, 256, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 1024, 0, 8192, 8192, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 5120, 8192, 3072, 0));
		pending_pairs.push_back(make_pair(100, 200, 300, 100, 200, 3372, 1500, 4000, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 3071, 0, 0, 1, 0, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 3072, 0, 0, 1, 2, 0));
		pending_pairs.push_back(make_pair(-300, 400, -500, 1700, -1600, 1500, 3000, 2500, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 1, 65535, 3072, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, 3000, 3000, 3000, 6000, 5000, 0));
		drain();

		// Random pairs across several contact radii
		foreach (radii[i]) begin
			write_radius(radii[i]);
			repeat (($urandom_range(0, 1) == 0) ? 150 : 200)
				pending_pairs.push_back(random_pair());
			drain();
		end

		if (failed == 0 && expected_contacts.size() == 0) begin
			$display("tb_pair_contact_probability passed");
		end else begin
			$display("tb_pair_contact_probability failed");
		end
		$finish;
	end

	// Hard limit on run time
	initial begin
		#5ms;
		$display("tb_pair_contact_probability failed");
		$finish;
	end

endmodule

### pair_contact_probability.f
design/pcp_pkg.sv
design/pcp_if.sv
design/pcp_dir.sv
design/pair_contact_probability.sv
dv/tb_pair_contact_probability.sv
